FILE: rtl/core/tree_ancestor_bitmask_table_macros.svh
// Assertion helpers for the ancestor table RTL.
`ifndef TREE_ANCESTOR_BITMASK_TABLE_MACROS_SVH
`define TREE_ANCESTOR_BITMASK_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TABT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define TABT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TABT_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define TABT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/core/tabt_pkg.sv
`timescale 1ns / 1ps

package tabt_pkg;

  localparam int MAX_NODES_DEF = 64;

  localparam int NODE_W = 6;
  localparam int PAR_W  = 7;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_TOPO   = 2'd1;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd2;

  typedef struct packed {
    logic              wr_en;
    logic [STAT_W-1:0] status;
    logic              hit;
    logic [CNT_W-1:0]  count_nxt;
    logic              bad_nxt;
  } eval_t;

endpackage

FILE: rtl/core/tabt_row_mem.sv
`timescale 1ns / 1ps

module tabt_row_mem import tabt_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
  input  logic [MAX_NODES-1:0]         wr_data,
  output logic [MAX_NODES-1:0]         rd_data
);

  logic [MAX_NODES-1:0] mem [MAX_NODES];
  logic [MAX_NODES-1:0] rdata_r;
  logic [MAX_NODES-1:0] fwd_data_r;
  logic                 fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    fwd_data_r <= wr_data;
  end

  // a row written in the same cycle it is read comes from the write bus
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rdata_r;

endmodule

FILE: rtl/core/tabt_eval.sv
`timescale 1ns / 1ps

module tabt_eval import tabt_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                     valid,
  input  logic                     mode,
  input  logic [NODE_W-1:0]        node,
  input  logic signed [PAR_W-1:0]  parent,
  input  logic [NODE_W-1:0]        cand,
  input  logic [CNT_W-1:0]         eff_n,
  input  logic [CNT_W-1:0]         loaded_count,
  input  logic                     build_bad,
  input  logic [MAX_NODES-1:0]     row_in,
  output eval_t                    res,
  output logic [MAX_NODES-1:0]     row_out
);

  localparam int AW = $clog2(MAX_NODES);

  logic                    restart;
  logic [CNT_W-1:0]        cnt_eff;
  logic                    bad_eff;
  logic                    load_ok;
  logic                    node_in;
  logic                    cand_in;
  logic signed [PAR_W-1:0] node_s;
  logic [MAX_NODES-1:0]    own_bit;

  assign restart = (node == '0);
  assign cnt_eff = restart ? '0 : loaded_count;
  assign bad_eff = restart ? 1'b0 : build_bad;
  assign node_in = ({1'b0, node} < eff_n);
  assign cand_in = ({1'b0, cand} < eff_n);
  assign node_s  = $signed({1'b0, node});

  assign load_ok = ({1'b0, node} == cnt_eff) && node_in &&
                   (parent >= -7'sd1) && (parent < node_s);

  assign own_bit = {{(MAX_NODES-1){1'b0}}, 1'b1} << node[AW-1:0];
  assign row_out = ((parent >= 7'sd0) ? row_in : '0) | own_bit;

  always_comb begin
    res.wr_en     = 1'b0;
    res.status    = ST_OK;
    res.hit       = 1'b0;
    res.count_nxt = loaded_count;
    res.bad_nxt   = build_bad;
    if (valid) begin
      case (mode)
        MODE_LOAD: begin
          if (load_ok) begin
            res.wr_en     = 1'b1;
            res.count_nxt = cnt_eff + 7'd1;
            res.bad_nxt   = bad_eff;
          end else begin
            res.status    = ST_TOPO;
            res.count_nxt = cnt_eff;
            res.bad_nxt   = 1'b1;
          end
        end
        MODE_QUERY: begin
          if (!node_in || !cand_in || (loaded_count != eff_n) || build_bad) begin
            res.status = ST_REJECT;
          end else begin
            res.hit = row_in[cand[AW-1:0]];
          end
        end
        default: begin
          res.status = ST_OK;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/tree_ancestor_bitmask_table.sv
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// in        start / busy            in_mode, in_node, in_parent, in_candidate
// out       out_valid (strobe)      out_status, out_is_ancestor
// cfg       cfg_valid / cfg_ready   cfg_node_count
//
// One word per cycle; busy stays low. The first step reads the parent (load)
// or node (query) row from the row RAM; the second checks, writes the new row
// and registers the result. A row written in the second step and read by the
// next word is forwarded inside the RAM block.
// Synchronous reset clears counters and flags; rows are not cleared.
// cfg_ready drops while a word is in flight. The receiver cannot stall.

`include "tree_ancestor_bitmask_table_macros.svh"

module tree_ancestor_bitmask_table import tabt_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_mode,
  input  logic [NODE_W-1:0]       in_node,
  input  logic signed [PAR_W-1:0] in_parent,
  input  logic [NODE_W-1:0]       in_candidate,
  output logic                    out_valid,
  output logic [STAT_W-1:0]       out_status,
  output logic                    out_is_ancestor,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CNT_W-1:0]        cfg_node_count
);

  localparam int AW = $clog2(MAX_NODES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NODES);

  logic                    accept;
  logic [AW-1:0]           rd_addr;
  logic [MAX_NODES-1:0]    row_rd;
  logic [MAX_NODES-1:0]    row_wr;
  logic [CNT_W-1:0]        eff_n;
  eval_t                   ev;

  logic                    s1_valid_r;
  logic                    s1_mode_r;
  logic [NODE_W-1:0]       s1_node_r;
  logic signed [PAR_W-1:0] s1_parent_r;
  logic [NODE_W-1:0]       s1_cand_r;
  logic [CNT_W-1:0]        node_count_r;
  logic [CNT_W-1:0]        loaded_r;
  logic                    build_bad_r;
  logic                    out_valid_r;
  logic [STAT_W-1:0]       out_status_r;
  logic                    out_hit_r;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign cfg_ready = !s1_valid_r;
  assign rd_addr   = (in_mode == MODE_QUERY) ? in_node[AW-1:0] : in_parent[AW-1:0];
  assign eff_n     = (node_count_r > MAX_CNT) ? MAX_CNT : node_count_r;

  tabt_row_mem #(.MAX_NODES(MAX_NODES)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .wr_en   (ev.wr_en),
    .wr_addr (s1_node_r[AW-1:0]),
    .wr_data (row_wr),
    .rd_data (row_rd)
  );

  tabt_eval #(.MAX_NODES(MAX_NODES)) u_eval (
    .valid        (s1_valid_r),
    .mode         (s1_mode_r),
    .node         (s1_node_r),
    .parent       (s1_parent_r),
    .cand         (s1_cand_r),
    .eff_n        (eff_n),
    .loaded_count (loaded_r),
    .build_bad    (build_bad_r),
    .row_in       (row_rd),
    .res          (ev),
    .row_out      (row_wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      node_count_r <= NODE_COUNT_RST;
      loaded_r     <= '0;
      build_bad_r  <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      out_valid_r <= s1_valid_r;
      loaded_r    <= ev.count_nxt;
      build_bad_r <= ev.bad_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_node_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r   <= in_mode;
      s1_node_r   <= in_node;
      s1_parent_r <= in_parent;
      s1_cand_r   <= in_candidate;
    end
    out_status_r <= ev.status;
    out_hit_r    <= ev.hit;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_is_ancestor = out_hit_r;

  `TABT_ASSERT_NEXT(a_word_reaches_eval, clk, rst_n, accept, s1_valid_r)
  `TABT_ASSERT_NEXT(a_result_follows, clk, rst_n, s1_valid_r, out_valid)
  `TABT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, loaded_r <= MAX_CNT)
  `TABT_ASSERT_NOW(a_topo_marks_bad, clk, rst_n,
                   out_valid && (out_status == ST_TOPO), build_bad_r)
  `TABT_ASSERT_NOW(a_hit_only_ok, clk, rst_n,
                   out_valid && out_is_ancestor, out_status == ST_OK)

endmodule

FILE: dv/tree_ancestor_bitmask_table_tb.sv
`timescale 1ns / 1ps

module tree_ancestor_bitmask_table_tb;
  import tabt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int WORD_TARGET = 1800;
  localparam int PHASE_WORDS = 150;
  localparam int DIR_ROWS    = 29;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              hit;
  } anc_result_t;

  typedef struct packed {
    logic              is_cfg;
    logic [CNT_W-1:0]  count;
    logic              mode;
    logic [NODE_W-1:0] node;
    logic [PAR_W-1:0]  parent;
    logic [NODE_W-1:0] cand;
    logic              typed;
    anc_result_t       res;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    in_mode = MODE_LOAD;
  logic [NODE_W-1:0]       in_node = '0;
  logic signed [PAR_W-1:0] in_parent = '0;
  logic [NODE_W-1:0]       in_candidate = '0;
  logic                    out_valid;
  logic [STAT_W-1:0]       out_status;
  logic                    out_is_ancestor;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CNT_W-1:0]        cfg_node_count = NODE_COUNT_RST;

  // predictor state
  logic [63:0]      anc_rows [0:MAX_NODES_DEF-1];
  logic [CNT_W-1:0] built_cnt = '0;
  logic             build_broken = 1'b0;
  logic [CNT_W-1:0] node_count_reg = NODE_COUNT_RST;

  anc_result_t pending_results [$];
  anc_result_t seen_exp;
  dir_row_t    dir_tab [DIR_ROWS];
  int          errors = 0;
  int          cycles = 0;
  int          words_sent = 0;
  int          gap_pct = 0;

  tree_ancestor_bitmask_table uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_node         (in_node),
    .in_parent       (in_parent),
    .in_candidate    (in_candidate),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_is_ancestor (out_is_ancestor),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_node_count  (cfg_node_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int eff_count();
    return (node_count_reg > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(node_count_reg);
  endfunction

  task automatic predict_ancestry(input logic mode, input logic [NODE_W-1:0] node,
                                  input logic signed [PAR_W-1:0] parent,
                                  input logic [NODE_W-1:0] cand, output anc_result_t res);
    int          eff;
    int          nd;
    int          cd;
    int          par;
    logic [63:0] row;
    eff = eff_count();
    nd = node;
    cd = cand;
    par = parent;
    res.status = ST_OK;
    res.hit = 1'b0;
    if (mode == MODE_LOAD) begin
      if (nd == 0) begin
        built_cnt = '0;
        build_broken = 1'b0;
      end
      if (nd == int'(built_cnt) && nd < eff && par >= -1 && par < nd) begin
        row = (par >= 0) ? anc_rows[par] : '0;
        row[nd] = 1'b1;
        anc_rows[nd] = row;
        built_cnt = built_cnt + 1'b1;
      end else begin
        build_broken = 1'b1;
        res.status = ST_TOPO;
      end
    end else begin
      if (nd >= eff || cd >= eff || int'(built_cnt) != eff || build_broken)
        res.status = ST_REJECT;
      else
        res.hit = anc_rows[nd][cd];
    end
  endtask

  // entered and left at a falling edge
  task automatic send_word(input logic mode, input logic [NODE_W-1:0] node,
                           input logic [PAR_W-1:0] parent, input logic [NODE_W-1:0] cand,
                           input bit use_typed, input anc_result_t typed_res);
    anc_result_t res;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_node <= node;
    in_parent <= parent;
    in_candidate <= cand;
    do @(posedge clk); while (busy !== 1'b0);
    predict_ancestry(mode, node, parent, cand, res);
    pending_results.push_back(use_typed ? typed_res : res);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_node_count(input logic [CNT_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_node_count <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    node_count_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic rand_load(input int node, input int parent);
    send_word(MODE_LOAD, node[NODE_W-1:0], parent[PAR_W-1:0],
              NODE_W'($urandom_range(63)), 1'b0, '0);
  endtask

  // well-formed build, optionally with one bad word somewhere inside
  task automatic load_tree(input bit broken);
    int eff;
    int bad_at;
    int i;
    int p;
    eff = eff_count();
    bad_at = (broken && eff > 0) ? $urandom_range(eff - 1) : -1;
    for (i = 0; i < eff; i++) begin
      if (i == bad_at) begin
        case ($urandom_range(2))
          0: rand_load(i, $urandom_range(i, 63));
          1: rand_load(i, -$urandom_range(2, 64));
          default: rand_load(i + 1, (i == 0) ? -1 : $urandom_range(i - 1));
        endcase
        if ($urandom_range(1)) break;
      end else begin
        p = (i == 0 || $urandom_range(3) == 0) ? -1 : $urandom_range(i - 1);
        rand_load(i, p);
      end
    end
  endtask

  task automatic ask_queries(input int k, input bit wide);
    int eff;
    int j;
    int t;
    int nd;
    int cd;
    eff = eff_count();
    for (j = 0; j < k; j++) begin
      nd = (wide || eff == 0) ? $urandom_range(63) : $urandom_range(eff - 1);
      cd = (wide || eff == 0) ? $urandom_range(63) : $urandom_range(eff - 1);
      // lean toward real ancestors so hits are common
      if (!wide && $urandom_range(1))
        for (t = 0; t < 6; t++) begin
          cd = $urandom_range(nd);
          if (anc_rows[nd][cd]) break;
        end
      send_word(MODE_QUERY, nd[NODE_W-1:0], PAR_W'($urandom_range(127)), cd[NODE_W-1:0],
                1'b0, '0);
    end
  endtask

  initial begin
    int r;
    int phase;
    int phase_start;
    int i;
    logic [CNT_W-1:0] cnt;

    for (i = 0; i < MAX_NODES_DEF; i++) anc_rows[i] = '0;

    dir_tab[0]  = '{1'b0, 7'd0, MODE_QUERY, 6'd0, 7'd0, 6'd0, 1'b1, '{ST_REJECT, 1'b0}};
    dir_tab[1]  = '{1'b0, 7'd0, MODE_LOAD, 6'd3, -7'sd1, 6'd0, 1'b1, '{ST_TOPO, 1'b0}};
    dir_tab[2]  = '{1'b0, 7'd0, MODE_LOAD, 6'd0, -7'sd1, 6'd63, 1'b1, '{ST_OK, 1'b0}};
    dir_tab[3]  = '{1'b0, 7'd0, MODE_LOAD, 6'd1, 7'd1, 6'd0, 1'b1, '{ST_TOPO, 1'b0}};
    dir_tab[4]  = '{1'b0, 7'd0, MODE_LOAD, 6'd0, 7'd0, 6'd0, 1'b1, '{ST_TOPO, 1'b0}};
    dir_tab[5]  = '{1'b0, 7'd0, MODE_LOAD, 6'd0, 7'h40, 6'd0, 1'b1, '{ST_TOPO, 1'b0}};
    dir_tab[6]  = '{1'b1, 7'd3, MODE_LOAD, 6'd0, 7'd0, 6'd0, 1'b0, '{ST_OK, 1'b0}};
    dir_tab[7]  = '{1'b0, 7'd0, MODE_LOAD, 6'd0, -7'sd1, 6'd0, 1'b1, '{ST_OK, 1'b0}};
    dir_tab[8]  = '{1'b0, 7'd0, MODE_LOAD, 6'd1, 7'd0, 6'd0, 1'b1, '{ST_OK, 1'b0}};
    dir_tab[9]  = '{1'b0, 7'd0, MODE_LOAD, 6'd2, 7'd63, 6'd0, 1'b1, '{ST_TOPO, 1'b0}};
    dir_tab[10] = '{1'b0, 7'd0, MODE_QUERY, 6'd1, 7'd0, 6'd0, 1'b1, '{ST_REJECT, 1'b0}};
    dir_tab[11] = '{1'b0, 7'd0, MODE_LOAD, 6'd0, -7'sd1, 6'd0, 1'b0, '{ST_OK, 1'b0}};
    dir_tab[12] = '{1'b0, 7'd0, MODE_LOAD, 6'd1, 7'd0, 6'd0, 1'b0, '{ST_OK, 1'b0}};
    dir_tab[13] = '{1'b0, 7'd0, MODE_LOAD, 6'd2, 7'd1, 6'd0, 1'b0, '{ST_OK, 1'b0}};
    dir_tab[14] = '{1'b0, 7'd0, MODE_QUERY, 6'd2, 7'h7f, 6'd0, 1'b0, '{ST_OK, 1'b0}};
    dir_tab[15] = '{1'b0, 7'd0, MODE_QUERY, 6'd2, 7'd0, 6'd2, 1'b0, '{ST_OK, 1'b0}};
    dir_tab[16] = '{1'b0, 7'd0, MODE_QUERY, 6'd0, 7'd0, 6'd2, 1'b0, '{ST_OK, 1'b0}};
    dir_tab[17] = '{1'b0, 7'd0, MODE_QUERY, 6'd3, 7'd0, 6'd0, 1'b1, '{ST_REJECT, 1'b0}};
    dir_tab[18] = '{1'b0, 7'd0, MODE_QUERY, 6'd63, 7'd0, 6'd63, 1'b1, '{ST_REJECT, 1'b0}};
    dir_tab[19] = '{1'b0, 7'd0, MODE_LOAD, 6'd3, 7'd2, 6'd0, 1'b1, '{ST_TOPO, 1'b0}};
    dir_tab[20] = '{1'b0, 7'd0, MODE_QUERY, 6'd1, 7'd0, 6'd0, 1'b1, '{ST_REJECT, 1'b0}};
    dir_tab[21] = '{1'b1, 7'd0, MODE_LOAD, 6'd0, 7'd0, 6'd0, 1'b0, '{ST_OK, 1'b0}};
    dir_tab[22] = '{1'b0, 7'd0, MODE_LOAD, 6'd0, -7'sd1, 6'd0, 1'b1, '{ST_TOPO, 1'b0}};
    dir_tab[23] = '{1'b0, 7'd0, MODE_QUERY, 6'd0, 7'd0, 6'd0, 1'b1, '{ST_REJECT, 1'b0}};
    dir_tab[24] = '{1'b1, 7'd1, MODE_LOAD, 6'd0, 7'd0, 6'd0, 1'b0, '{ST_OK, 1'b0}};
    dir_tab[25] = '{1'b0, 7'd0, MODE_LOAD, 6'd0, -7'sd1, 6'd0, 1'b1, '{ST_OK, 1'b0}};
    dir_tab[26] = '{1'b0, 7'd0, MODE_QUERY, 6'd0, 7'd0, 6'd0, 1'b0, '{ST_OK, 1'b0}};
    // count above the row limit clamps; the one-node build is now incomplete
    dir_tab[27] = '{1'b1, 7'd127, MODE_LOAD, 6'd0, 7'd0, 6'd0, 1'b0, '{ST_OK, 1'b0}};
    dir_tab[28] = '{1'b0, 7'd0, MODE_QUERY, 6'd0, 7'd0, 6'd0, 1'b1, '{ST_REJECT, 1'b0}};

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].is_cfg)
        write_node_count(dir_tab[i].count);
      else
        send_word(dir_tab[i].mode, dir_tab[i].node, dir_tab[i].parent, dir_tab[i].cand,
                  dir_tab[i].typed, dir_tab[i].res);
    end

    phase = 0;
    while (words_sent < WORD_TARGET) begin
      case (phase)
        0, 6:    cnt = 7'd64;
        1:       cnt = 7'd1;
        2:       cnt = 7'd2;
        3:       cnt = 7'd127;
        4:       cnt = 7'd0;
        5:       cnt = 7'd7;
        default: cnt = CNT_W'($urandom_range(1, 64));
      endcase
      case (phase % 3)
        0:       gap_pct = 0;
        1:       gap_pct = 66;
        default: gap_pct = 17;
      endcase
      write_node_count(cnt);
      phase_start = words_sent;
      // old build seen through the new count
      ask_queries(3, 1'b0);
      while (words_sent - phase_start < PHASE_WORDS) begin
        r = $urandom_range(99);
        if (r < 60) begin
          load_tree($urandom_range(4) == 0);
          ask_queries($urandom_range(5, 25), 1'b0);
        end else if (r < 80) begin
          ask_queries($urandom_range(1, 6), 1'b1);
        end else begin
          repeat ($urandom_range(1, 4))
            send_word(MODE_LOAD, NODE_W'($urandom_range(63)), PAR_W'($urandom_range(127)),
                      NODE_W'($urandom_range(63)), 1'b0, '0);
        end
      end
      phase++;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("tree_ancestor_bitmask_table_tb OK");
    else
      $display("tree_ancestor_bitmask_table_tb NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, status %0d is_ancestor %0d", $time, out_status,
                 out_is_ancestor);
      end else begin
        seen_exp = pending_results.pop_front();
        if (out_status !== seen_exp.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, seen_exp.status, out_status);
        end
        if (out_is_ancestor !== seen_exp.hit) begin
          errors++;
          $display("%0t: is_ancestor expected %0d got %0d", $time, seen_exp.hit,
                   out_is_ancestor);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tree_ancestor_bitmask_table_tb NOT OK");
      $finish;
    end
  end

endmodule
